[design/bmps_pkg.sv]
// Shared types and codes for the bitmap pixel stream decoder.
package bmps_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_PIXEL     = 2'd1;
  localparam logic [1:0] KIND_BAD_DEPTH = 2'd2;

  // Fixed widths of the result fields
  localparam int unsigned ADDR_OUT_W = 32;
  localparam int unsigned DIM_OUT_W  = 16;

  // One result item
  typedef struct packed {
    logic [1:0]            kind;
    logic [ADDR_OUT_W-1:0] addr;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [DIM_OUT_W-1:0]  width;
    logic [DIM_OUT_W-1:0]  height;
    logic [15:0]           bpp;
    logic                  last;
  } result_t;

  // Flow control from the output queue to the parser
  typedef struct packed {
    logic accept;  // input item taken this cycle
    logic drain;   // parser result moves into the output queue
  } pipe_ctl_t;

endpackage

[design/bmp_pixel_stream_decoder_unit.sv]
// Top level of the bitmap pixel stream decoder: parser plus two-entry output queue.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+-----------------
//  in      | input     | in_data_byte, in_start_of_file          | in_valid/in_stall
//  out     | output    | out_kind ... out_last_pixel             | out_valid/out_stall
//
// One byte per cycle while in_stall is low; a result passes the parser register,
// then the output register (the palette read is registered alongside).
// Reset is synchronous, active low; the parser waits for a start-of-file byte.
// in_stall is driven from registers only: it rises when the output register
// and its skid entry are both full and the parser holds a pending result.
module bmp_pixel_stream_decoder_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned DIM_BITS        = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_pixel_address,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [15:0] out_image_width,
  output logic [15:0] out_image_height,
  output logic [15:0] out_bits_per_pixel,
  output logic        out_last_pixel
);
  import bmps_pkg::*;

  pipe_ctl_t ctl;
  logic      par_valid;
  result_t   par_res;
  logic      out_valid_r, skid_valid_r;
  result_t   out_r, skid_r;
  logic      pop;

  // Flow control
  assign in_stall   = par_valid && skid_valid_r;
  assign ctl.accept = in_valid && !in_stall;
  assign ctl.drain  = par_valid && !skid_valid_r;
  assign pop        = out_valid_r && !out_stall;

  bmps_parser #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .DIM_BITS        (DIM_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .data_byte     (in_data_byte),
    .start_of_file (in_start_of_file),
    .res_valid     (par_valid),
    .res           (par_res)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= ctl.drain;
      end
    end else if (ctl.drain) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (ctl.drain) begin
        out_r <= par_res;
      end
    end else if (ctl.drain) begin
      skid_r <= par_res;
    end
  end

  // Result ports
  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_pixel_address  = out_r.addr;
  assign out_red            = out_r.red;
  assign out_green          = out_r.green;
  assign out_blue           = out_r.blue;
  assign out_alpha          = out_r.alpha;
  assign out_image_width    = out_r.width;
  assign out_image_height   = out_r.height;
  assign out_bits_per_pixel = out_r.bpp;
  assign out_last_pixel     = out_r.last;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r)
    else $error("skid entry not drained after output taken");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.kind == KIND_HEADER || out_r.kind == KIND_PIXEL ||
                     out_r.kind == KIND_BAD_DEPTH))
    else $error("unknown result kind");

  a_non_pixel_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.kind != KIND_PIXEL |->
      (out_r.addr == '0 && out_r.last == 1'b0 && out_r.red == '0 &&
       out_r.green == '0 && out_r.blue == '0 && out_r.alpha == '0))
    else $error("header or depth item carries pixel data");

endmodule

[design/bmps_parser.sv]
// Byte parser: header fields, palette memory, pixel assembly and addressing.
module bmps_parser #(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned DIM_BITS        = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmps_pkg::pipe_ctl_t ctl,
  input  logic [7:0]          data_byte,
  input  logic                start_of_file,
  output logic                res_valid,
  output bmps_pkg::result_t   res
);
  import bmps_pkg::*;

  localparam int unsigned IDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned ADDR_W = 2 * DIM_BITS;

  // Parser phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_PALETTE = 3'd2;
  localparam logic [2:0] PH_PIXELS  = 3'd3;
  localparam logic [2:0] PH_PAD     = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  localparam logic [9:0] HDR_WIDTH_END  = 10'd7;
  localparam logic [9:0] HDR_HEIGHT_END = 10'd11;
  localparam logic [9:0] HDR_DEPTH_END  = 10'd15;
  localparam logic [9:0] HDR_LAST       = 10'd107;
  localparam logic [9:0] PAL_LAST       = 10'(4 * PALETTE_ENTRIES - 1);
  localparam logic [8:0] PAL_LIMIT      = 9'(PALETTE_ENTRIES);

  localparam logic [15:0] DEPTH_8  = 16'd8;
  localparam logic [15:0] DEPTH_24 = 16'd24;
  localparam logic [15:0] DEPTH_32 = 16'd32;

  // Parser state
  logic [2:0]          phase_r, phase_nxt;
  logic [9:0]          cnt_r, cnt_nxt;
  logic [31:0]         hw_r, hw_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [15:0]         depth_r, depth_nxt;
  logic [23:0]         pb_r, pb_nxt;
  logic [1:0]          bip_r, bip_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] rows_r, rows_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;

  // Values seen by this byte after a possible restart
  logic [2:0]          ph_eff;
  logic [9:0]          cnt_eff;
  logic [31:0]         hw_eff;
  logic [DIM_BITS-1:0] width_eff, height_eff;
  logic [15:0]         depth_eff;

  logic                emit, use_pal, pal_hit, pal_we, start_px;
  logic                is8, is24;
  logic [1:0]          row_bytes_lo, row_pad;
  logic [DIM_BITS:0]   col_inc;
  logic [IDX_W-1:0]    pal_entry;
  logic [1:0]          pal_lane;
  result_t             res_nxt;

  // Registered stage toward the output queue
  logic                s1_valid_r;
  result_t             s1_res_r;
  logic                s1_pal_r, s1_hit_r;
  logic [31:0]         pal_rd_r;
  logic [31:0]         pal_mem [PALETTE_ENTRIES];

  // Restart view
  always_comb begin
    ph_eff     = start_of_file ? PH_HEADER : phase_r;
    cnt_eff    = start_of_file ? '0 : cnt_r;
    hw_eff     = start_of_file ? '0 : hw_r;
    width_eff  = start_of_file ? '0 : width_r;
    height_eff = start_of_file ? '0 : height_r;
    depth_eff  = start_of_file ? '0 : depth_r;
  end

  // Depth-derived values
  assign is8          = (depth_eff == DEPTH_8);
  assign is24         = (depth_eff == DEPTH_24);
  assign row_bytes_lo = is8 ? width_eff[1:0] :
                        (is24 ? 2'(width_eff[1:0] * 2'd3) : 2'd0);
  assign row_pad      = 2'd0 - row_bytes_lo;
  assign col_inc      = (DIM_BITS + 1)'(col_r) + 1'b1;
  assign pal_entry    = cnt_eff[IDX_W+1:2];
  assign pal_lane     = cnt_eff[1:0];
  assign pal_hit      = ({1'b0, data_byte} < PAL_LIMIT);

  // Next-state logic for one byte
  always_comb begin
    phase_nxt  = ph_eff;
    cnt_nxt    = cnt_eff;
    hw_nxt     = hw_eff;
    width_nxt  = width_eff;
    height_nxt = height_eff;
    depth_nxt  = depth_eff;
    pb_nxt     = pb_r;
    bip_nxt    = bip_r;
    col_nxt    = col_r;
    rows_nxt   = rows_r;
    pad_nxt    = pad_r;
    base_nxt   = base_r;
    emit       = 1'b0;
    use_pal    = 1'b0;
    pal_we     = 1'b0;
    start_px   = 1'b0;
    res_nxt    = '0;

    unique case (ph_eff)
      PH_HEADER: begin
        hw_nxt = {data_byte, hw_eff[31:8]};
        if (cnt_eff == HDR_WIDTH_END)  width_nxt  = hw_nxt[DIM_BITS-1:0];
        if (cnt_eff == HDR_HEIGHT_END) height_nxt = hw_nxt[DIM_BITS-1:0];
        if (cnt_eff == HDR_DEPTH_END)  depth_nxt  = hw_nxt[31:16];
        if (cnt_eff < HDR_LAST) begin
          cnt_nxt = cnt_eff + 1'b1;
        end else begin
          cnt_nxt = '0;
          emit    = 1'b1;
          if (is8) begin
            phase_nxt    = PH_PALETTE;
            res_nxt.kind = KIND_HEADER;
          end else if (is24 || depth_eff == DEPTH_32) begin
            start_px     = 1'b1;
            res_nxt.kind = KIND_HEADER;
          end else begin
            phase_nxt    = PH_DONE;
            res_nxt.kind = KIND_BAD_DEPTH;
          end
        end
      end
      PH_PALETTE: begin
        pal_we = 1'b1;
        if (cnt_eff >= PAL_LAST) begin
          cnt_nxt  = '0;
          start_px = 1'b1;
        end else begin
          cnt_nxt = cnt_eff + 1'b1;
        end
      end
      PH_PIXELS: begin
        if (is8) begin
          emit    = 1'b1;
          use_pal = 1'b1;
        end else if (bip_r < (is24 ? 2'd2 : 2'd3)) begin
          pb_nxt  = pb_r | (24'(data_byte) << {bip_r, 3'b000});
          bip_nxt = bip_r + 1'b1;
        end else begin
          emit          = 1'b1;
          res_nxt.blue  = pb_r[7:0];
          res_nxt.green = pb_r[15:8];
          res_nxt.red   = is24 ? data_byte : pb_r[23:16];
          res_nxt.alpha = is24 ? 8'hFF : data_byte;
        end
        if (emit) begin
          res_nxt.kind = KIND_PIXEL;
          res_nxt.addr = ADDR_OUT_W'(base_r + ADDR_W'(col_r));
          res_nxt.last = (rows_r == DIM_BITS'(1)) && (col_inc == {1'b0, width_eff});
          pb_nxt  = '0;
          bip_nxt = '0;
          // End of row: step the base back by one row width, then skip padding
          if (col_inc >= {1'b0, width_eff}) begin
            col_nxt = '0;
            if (rows_r <= DIM_BITS'(1)) begin
              rows_nxt  = '0;
              phase_nxt = PH_DONE;
            end else begin
              rows_nxt = rows_r - 1'b1;
              base_nxt = base_r - ADDR_W'(width_eff);
              pad_nxt  = row_pad;
              if (row_pad != 2'd0) phase_nxt = PH_PAD;
            end
          end else begin
            col_nxt = col_inc[DIM_BITS-1:0];
          end
        end
      end
      PH_PAD: begin
        pad_nxt = pad_r - 1'b1;
        if (pad_nxt == 2'd0) phase_nxt = PH_PIXELS;
      end
      default: begin
        // idle or finished: byte ignored
      end
    endcase

    // Pixel section setup; an empty image finishes at once
    if (start_px) begin
      if (width_nxt == '0 || height_nxt == '0) begin
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_PIXELS;
        rows_nxt  = height_nxt;
        col_nxt   = '0;
        base_nxt  = ADDR_W'(height_nxt - 1'b1) * ADDR_W'(width_nxt);
        pb_nxt    = '0;
        bip_nxt   = '0;
        pad_nxt   = '0;
      end
    end

    res_nxt.width  = DIM_OUT_W'(width_nxt);
    res_nxt.height = DIM_OUT_W'(height_nxt);
    res_nxt.bpp    = depth_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      bip_r   <= '0;
      pad_r   <= '0;
    end else if (ctl.accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      bip_r   <= bip_nxt;
      pad_r   <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      hw_r     <= hw_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      pb_r     <= pb_nxt;
      col_r    <= col_nxt;
      rows_r   <= rows_nxt;
      base_r   <= base_nxt;
    end
  end

  // Palette memory: byte-lane write, registered read
  always_ff @(posedge clk) begin
    if (ctl.accept && pal_we) begin
      pal_mem[pal_entry][{pal_lane, 3'b000} +: 8] <= data_byte;
    end
    if (ctl.accept) begin
      pal_rd_r <= pal_mem[data_byte[IDX_W-1:0]];
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ctl.accept) begin
      s1_valid_r <= emit;
    end else if (ctl.drain) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_res_r <= res_nxt;
      s1_pal_r <= use_pal;
      s1_hit_r <= pal_hit;
    end
  end

  // Palette colors join here; entry is BGRA from low byte up
  always_comb begin
    res = s1_res_r;
    if (s1_pal_r) begin
      res.blue  = s1_hit_r ? pal_rd_r[7:0]   : 8'd0;
      res.green = s1_hit_r ? pal_rd_r[15:8]  : 8'd0;
      res.red   = s1_hit_r ? pal_rd_r[23:16] : 8'd0;
      res.alpha = s1_hit_r ? pal_rd_r[31:24] : 8'd0;
    end
  end

  assign res_valid = s1_valid_r;

endmodule
